>>> rtl/mi3_pkg.sv
// Shared types, widths and cofactor index tables for the 3x3 matrix inverse core.
package mi3_pkg;

  localparam int QW   = 33;  // quotient bits before saturation
  localparam int DETW = 98;  // signed determinant working width
  localparam int MAGW = 96;  // determinant magnitude width
  localparam int COFW = 66;  // signed cofactor width
  localparam int NW   = 65;  // cofactor magnitude width

  typedef logic signed [31:0] elem_t;

  typedef struct packed {
    logic [MAGW-1:0] rem;
    logic [QW-1:0]   q;
    logic            lsb;
    logic            neg;
    logic            ovf;
  } lane_t;

  typedef struct packed {
    logic            sing;
    logic [MAGW-1:0] d;
    lane_t [8:0]     lane;
  } dstage_t;

  // element indexes of the two products of each adjugate entry: a*b - c*e
  localparam logic [3:0] IDX_A [9] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
  localparam logic [3:0] IDX_B [9] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
  localparam logic [3:0] IDX_C [9] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
  localparam logic [3:0] IDX_E [9] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

  // adjugate entries holding the first-row cofactors
  localparam logic [3:0] ROW1_COF [3] = '{4'd0, 4'd3, 4'd6};

  localparam logic [QW-1:0] LIM_POS = 33'h0_7FFF_FFFF;
  localparam logic [QW-1:0] LIM_NEG = 33'h0_8000_0000;

endpackage

>>> rtl/mi3_front.sv
// Input register, cofactors, determinant and divider setup for the matrix inverse core.
module mi3_front import mi3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        v_in,
  input  elem_t [8:0] m_in,
  output logic        v_out,
  output dstage_t     ds_out
);

  logic [7:0] v_r;

  elem_t [8:0]                 m_r;
  logic signed [63:0]          pa_r [9];
  logic signed [63:0]          pb_r [9];
  elem_t [2:0]                 m1a_r, m1b_r;
  logic signed [COFW-1:0]      c2_r [9];
  logic signed [COFW-1:0]      c3_r [9];
  logic signed [COFW-1:0]      c4_r [9];
  logic signed [COFW-1:0]      c5_r [9];
  logic signed [65:0]          ph_r [3];
  logic signed [64:0]          pl_r [3];
  logic signed [DETW-1:0]      t_r  [3];
  logic signed [DETW-1:0]      det_r;
  logic [NW-1:0]               n_r  [9];
  logic [8:0]                  neg_r;
  logic [MAGW-1:0]             d_r;
  logic                        sing_r;
  dstage_t                     ds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_in;
      for (int k = 0; k < 9; k++) begin
        pa_r[k] <= $signed(m_r[IDX_A[k]]) * $signed(m_r[IDX_B[k]]);
        pb_r[k] <= $signed(m_r[IDX_C[k]]) * $signed(m_r[IDX_E[k]]);
        c2_r[k] <= COFW'(pa_r[k]) - COFW'(pb_r[k]);
        c3_r[k] <= c2_r[k];
        c4_r[k] <= c3_r[k];
        c5_r[k] <= c4_r[k];
      end
      m1a_r <= m_r[2:0];
      m1b_r <= m1a_r;
      for (int j = 0; j < 3; j++) begin
        ph_r[j] <= $signed(m1b_r[j]) * $signed(c2_r[ROW1_COF[j]][65:32]);
        pl_r[j] <= $signed(m1b_r[j]) * $signed({1'b0, c2_r[ROW1_COF[j]][31:0]});
        t_r[j]  <= $signed({ph_r[j], 32'd0}) + DETW'(pl_r[j]);
      end
      det_r  <= t_r[0] + t_r[1] + t_r[2];
      for (int k = 0; k < 9; k++) begin
        n_r[k]   <= c5_r[k][COFW-1] ? NW'(-c5_r[k]) : NW'(c5_r[k]);
        neg_r[k] <= c5_r[k][COFW-1] ^ det_r[DETW-1];
      end
      d_r    <= det_r[DETW-1] ? MAGW'(-det_r) : MAGW'(det_r);
      sing_r <= (det_r == '0);
      ds_r.sing <= sing_r;
      ds_r.d    <= d_r;
      for (int k = 0; k < 9; k++) begin
        ds_r.lane[k].rem <= MAGW'(n_r[k][NW-1:1]);
        ds_r.lane[k].q   <= '0;
        ds_r.lane[k].lsb <= n_r[k][0];
        ds_r.lane[k].neg <= neg_r[k];
        ds_r.lane[k].ovf <= (97'(n_r[k]) >= {d_r, 1'b0});
      end
    end
  end

  assign v_out  = v_r[7];
  assign ds_out = ds_r;

endmodule

>>> rtl/mi3_div_step.sv
// One restoring-division step for all nine lanes of the matrix inverse core.
module mi3_div_step import mi3_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    v_in,
  input  dstage_t ds_in,
  output logic    v_out,
  output dstage_t ds_out
);

  logic    v_r;
  dstage_t ds_r, ds_nxt;
  logic [MAGW:0]   rem2 [9];
  logic [MAGW+1:0] diff [9];

  always_comb begin
    ds_nxt = ds_in;
    for (int k = 0; k < 9; k++) begin
      rem2[k] = {ds_in.lane[k].rem, ds_in.lane[k].lsb};
      diff[k] = {1'b0, rem2[k]} - {2'b00, ds_in.d};
      ds_nxt.lane[k].rem = diff[k][MAGW+1] ? rem2[k][MAGW-1:0] : diff[k][MAGW-1:0];
      ds_nxt.lane[k].q   = {ds_in.lane[k].q[QW-2:0], ~diff[k][MAGW+1]};
      ds_nxt.lane[k].lsb = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds_r <= ds_nxt;
    end
  end

  assign v_out  = v_r;
  assign ds_out = ds_r;

endmodule

>>> rtl/mi3_post.sv
// Saturation, sign and singular forcing into the output register of the matrix inverse core.
module mi3_post import mi3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        v_in,
  input  dstage_t     ds_in,
  output logic        v_out,
  output elem_t [8:0] res_out,
  output logic        sing_out
);

  logic        v_r;
  elem_t [8:0] res_r, res_nxt;
  logic        sing_r;
  logic [QW-1:0] lim [9];
  logic [QW-1:0] mag [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      lim[k] = ds_in.lane[k].neg ? LIM_NEG : LIM_POS;
      mag[k] = (ds_in.lane[k].ovf || ds_in.lane[k].q > lim[k]) ? lim[k] : ds_in.lane[k].q;
      if (ds_in.sing) begin
        res_nxt[k] = '0;
      end else if (ds_in.lane[k].neg) begin
        res_nxt[k] = 32'(-mag[k]);
      end else begin
        res_nxt[k] = 32'(mag[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      sing_r <= ds_in.sing;
    end
  end

  assign v_out    = v_r;
  assign res_out  = res_r;
  assign sing_out = sing_r;

endmodule

>>> rtl/matrix3_inverse_core.sv
// Top level of the pipelined 3x3 Q16.16 matrix inverse core.
// Takes one matrix beat per cycle unless a result beat stalls, and returns its
// inverse after the input register, cofactor, determinant and magnitude stages,
// the shared-step restoring divider (one quotient bit per stage for all nine
// elements) and one output register. Each element is cofactor/determinant
// truncated toward zero and saturated; a zero determinant raises out_singular
// and zeroes the result. The whole pipeline holds while a result beat stalls.
module matrix3_inverse_core import mi3_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_r1c1,
  input  logic signed [31:0] in_r1c2,
  input  logic signed [31:0] in_r1c3,
  input  logic signed [31:0] in_r2c1,
  input  logic signed [31:0] in_r2c2,
  input  logic signed [31:0] in_r2c3,
  input  logic signed [31:0] in_r3c1,
  input  logic signed [31:0] in_r3c2,
  input  logic signed [31:0] in_r3c3,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_r1c1,
  output logic signed [31:0] out_r1c2,
  output logic signed [31:0] out_r1c3,
  output logic signed [31:0] out_r2c1,
  output logic signed [31:0] out_r2c2,
  output logic signed [31:0] out_r2c3,
  output logic signed [31:0] out_r3c1,
  output logic signed [31:0] out_r3c2,
  output logic signed [31:0] out_r3c3,
  output logic               out_singular
);

  logic        en;
  elem_t [8:0] m_in;
  logic        dv [QW+1];
  dstage_t     ds [QW+1];
  elem_t [8:0] res;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign m_in = {in_r3c3, in_r3c2, in_r3c1, in_r2c3, in_r2c2, in_r2c1,
                 in_r1c3, in_r1c2, in_r1c1};

  mi3_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_in   (in_valid),
    .m_in   (m_in),
    .v_out  (dv[0]),
    .ds_out (ds[0])
  );

  for (genvar s = 0; s < QW; s++) begin : g_div
    mi3_div_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_in   (dv[s]),
      .ds_in  (ds[s]),
      .v_out  (dv[s+1]),
      .ds_out (ds[s+1])
    );
  end

  mi3_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (dv[QW]),
    .ds_in    (ds[QW]),
    .v_out    (out_valid),
    .res_out  (res),
    .sing_out (out_singular)
  );

  assign out_r1c1 = res[0];
  assign out_r1c2 = res[1];
  assign out_r1c3 = res[2];
  assign out_r2c1 = res[3];
  assign out_r2c2 = res[4];
  assign out_r2c3 = res[5];
  assign out_r3c1 = res[6];
  assign out_r3c2 = res[7];
  assign out_r3c3 = res[8];

`ifndef NO_ASSERTIONS
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |-> (res == '0))
    else $error("singular beat carries nonzero element");

  a_stall_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");
`endif

endmodule

>>> test/matrix3_inverse_core_tb.sv
// Self-checking testbench for the pipelined 3x3 Q16.16 matrix inverse core.
module matrix3_inverse_core_tb;
  import mi3_pkg::*;

  typedef struct packed {
    logic signed [31:0] e11, e12, e13, e21, e22, e23, e31, e32, e33;
  } mat_t;

  typedef struct packed {
    logic signed [31:0] e11, e12, e13, e21, e22, e23, e31, e32, e33;
    logic               sing;
  } inv_t;

  localparam int WATCHDOG = 5000;
  localparam int DRAIN    = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_r1c1 = '0, in_r1c2 = '0, in_r1c3 = '0;
  logic signed [31:0] in_r2c1 = '0, in_r2c2 = '0, in_r2c3 = '0;
  logic signed [31:0] in_r3c1 = '0, in_r3c2 = '0, in_r3c3 = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [31:0] out_r1c1, out_r1c2, out_r1c3, out_r2c1, out_r2c2, out_r2c3;
  logic signed [31:0] out_r3c1, out_r3c2, out_r3c3;
  logic out_singular;

  inv_t expected_inverses[$];
  int   mismatches = 0;
  int   idle_pct = 37;
  int   quiet_cycles = 0;

  matrix3_inverse_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] div_q16(logic signed [127:0] cof, logic signed [127:0] det);
    logic [127:0] n, d, q;
    logic         neg;
    logic [31:0]  lim;
    neg = cof[127] ^ det[127];
    n = cof[127] ? -cof : cof;
    d = det[127] ? -det : det;
    q = (n << 32) / d;
    lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (q > {96'd0, lim}) q = {96'd0, lim};
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic inv_t invert(mat_t m);
    logic signed [127:0] a11, a12, a13, a21, a22, a23, a31, a32, a33;
    logic signed [127:0] c [9];
    logic signed [127:0] det;
    inv_t r;
    a11 = m.e11; a12 = m.e12; a13 = m.e13;
    a21 = m.e21; a22 = m.e22; a23 = m.e23;
    a31 = m.e31; a32 = m.e32; a33 = m.e33;
    c[0] = a22 * a33 - a32 * a23;
    c[1] = a32 * a13 - a12 * a33;
    c[2] = a12 * a23 - a22 * a13;
    c[3] = a31 * a23 - a21 * a33;
    c[4] = a11 * a33 - a31 * a13;
    c[5] = a21 * a13 - a11 * a23;
    c[6] = a21 * a32 - a31 * a22;
    c[7] = a31 * a12 - a11 * a32;
    c[8] = a11 * a22 - a21 * a12;
    det = a11 * a22 * a33 + a12 * a23 * a31 + a13 * a21 * a32
        - a13 * a22 * a31 - a11 * a23 * a32 - a12 * a21 * a33;
    r = '0;
    if (det == 0) begin
      r.sing = 1'b1;
      return r;
    end
    r.e11 = div_q16(c[0], det); r.e12 = div_q16(c[1], det); r.e13 = div_q16(c[2], det);
    r.e21 = div_q16(c[3], det); r.e22 = div_q16(c[4], det); r.e23 = div_q16(c[5], det);
    r.e31 = div_q16(c[6], det); r.e32 = div_q16(c[7], det); r.e33 = div_q16(c[8], det);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic send_matrix(mat_t m);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_r1c1, in_r1c2, in_r1c3, in_r2c1, in_r2c2, in_r2c3, in_r3c1, in_r3c2, in_r3c3} <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_inverses.push_back(invert(m));
  endtask

  always @(posedge clk) begin
    inv_t w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_inverses.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          w = expected_inverses.pop_front();
          if (out_r1c1 !== w.e11) report_mismatch("r1c1", out_r1c1, w.e11);
          if (out_r1c2 !== w.e12) report_mismatch("r1c2", out_r1c2, w.e12);
          if (out_r1c3 !== w.e13) report_mismatch("r1c3", out_r1c3, w.e13);
          if (out_r2c1 !== w.e21) report_mismatch("r2c1", out_r2c1, w.e21);
          if (out_r2c2 !== w.e22) report_mismatch("r2c2", out_r2c2, w.e22);
          if (out_r2c3 !== w.e23) report_mismatch("r2c3", out_r2c3, w.e23);
          if (out_r3c1 !== w.e31) report_mismatch("r3c1", out_r3c1, w.e31);
          if (out_r3c2 !== w.e32) report_mismatch("r3c2", out_r3c2, w.e32);
          if (out_r3c3 !== w.e33) report_mismatch("r3c3", out_r3c3, w.e33);
          if (out_singular !== w.sing) begin
            report_mismatch("singular", 32'(out_singular), 32'(w.sing));
          end
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("FAIL matrix3_inverse_core");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(65535)) - 32768;
      2: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      3: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $signed($urandom_range(8)) - 4;
    endcase
  endfunction

  function automatic mat_t rand_matrix();
    mat_t m;
    m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
         rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    return m;
  endfunction

  task automatic test_directed();
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [31:0] MX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MN = 32'sh8000_0000;
    mat_t m;
    send_matrix('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
    send_matrix('{2 * ONE, 0, 0, 0, -4 * ONE, 0, 0, 0, ONE / 2});
    send_matrix('0);
    send_matrix('{ONE, 2 * ONE, 3 * ONE, 2 * ONE, 4 * ONE, 6 * ONE, 0, ONE, ONE});
    send_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1});
    send_matrix('{-1, 0, 0, 0, 1, 0, 0, 0, 1});
    send_matrix('{MX, 0, 0, 0, MX, 0, 0, 0, MX});
    send_matrix('{MN, 0, 0, 0, MN, 0, 0, 0, MN});
    send_matrix('{MN, MX, MN, MX, MN, MX, MN, MX, 1});
    send_matrix('{MX, MX, MX, MX, MX, MX, MX, MX, MX});
    send_matrix('{MN, MN, 0, 0, MN, MN, MN, 0, MN});
    send_matrix('{MX, MN, 5, -3, MX, 7, 9, -11, MN});
    send_matrix('{32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 3, ONE, -ONE, MN, 1, MX});
    m = '{ONE, ONE, 0, 0, ONE, ONE, ONE, 0, ONE};
    send_matrix(m);
    send_matrix('{1, 2, 3, 4, 5, 6, 7, 8, 10});
  endtask

  task automatic test_random(int count);
    mat_t m;
    for (int i = 0; i < count; i++) begin
      m = rand_matrix();
      if ($urandom_range(9) == 0) begin
        m.e31 = m.e21; m.e32 = m.e22; m.e33 = m.e23;
      end
      send_matrix(m);
    end
  endtask

  task automatic test_back_to_back(int count);
    idle_pct = 0;
    test_random(count);
    idle_pct = 37;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(900);
    test_back_to_back(300);
    test_random(550);
    in_valid <= 1'b0;
    while (expected_inverses.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS matrix3_inverse_core");
    end else begin
      $display("FAIL matrix3_inverse_core");
    end
    $finish;
  end

endmodule
